// ----- rtl/msrk_pkg.sv -----
package msrk_pkg;

  localparam int unsigned UPDATE_PERIOD = 10;
  localparam int unsigned KICK_SCALE = 8;
  localparam int unsigned SPEED_STEPS = 127;
  localparam logic [11:0] DUTY_MAX = 12'd4095;
  localparam logic [6:0] SPEED_ESTOP = 7'd1;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD = 1'b1;

  localparam logic [2:0] REG_ACCEL_RATE = 3'd0;
  localparam logic [2:0] REG_DECEL_RATE = 3'd1;
  localparam logic [2:0] REG_KICK_DURATION = 3'd2;
  localparam logic [2:0] REG_KICK_LEVEL = 3'd3;
  localparam logic [2:0] REG_START_VOLTAGE = 3'd4;
  localparam logic [2:0] REG_HIGH_VOLTAGE = 3'd5;

  typedef struct packed {
    logic [7:0] accel_rate;
    logic [7:0] decel_rate;
    logic [7:0] kick_duration;
    logic [7:0] kick_level;
    logic [7:0] start_voltage;
    logic [7:0] high_voltage;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [6:0] speed_value;
    logic       direction;
  } item_t;

endpackage

// ----- rtl/motor_speed_ramp_with_kick.sv -----
// an input transfer passes the input register, then the state/result registers, to result valid
// throughput: one item per cycle while out_stall is low; the state update sets the rate
// a result held by out_stall leaves room for one more input transfer, then in_stall rises
// reset: rst_n synchronous active low, clears speeds, counters, duties and registers;
// the period counter reloads to the update period
module motor_speed_ramp_with_kick (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [6:0]  in_speed_value,
  input  logic        in_direction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_ch1_duty,
  output logic [11:0] out_ch2_duty,
  output logic [6:0]  out_speed_now,
  output logic [6:0]  out_target_now,
  output logic        out_dir_now,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  msrk_pkg::cfg_t  cfg;
  msrk_pkg::item_t item_r;
  logic            in_valid_r;
  logic            out_valid_r;
  logic            fire;
  logic            in_take;

  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{req_type: in_req_type, speed_value: in_speed_value, direction: in_direction};
    end
  end

  msrk_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msrk_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item_r),
    .cfg      (cfg),
    .duty_one (out_ch1_duty),
    .duty_two (out_ch2_duty),
    .speed    (out_speed_now),
    .target   (out_target_now),
    .dir      (out_dir_now)
  );

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch1_duty == 12'd0) || (out_ch2_duty == 12'd0))
    else $error("both pwm channels driven");

  a_speed_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_speed_now == $past(out_speed_now)) ||
             (out_speed_now == $past(out_speed_now) + 7'd1) ||
             (out_speed_now == $past(out_speed_now) - 7'd1) ||
             (out_speed_now == 7'd0))
    else $error("speed moved more than one step");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(out_speed_now) && $stable(out_target_now) && $stable(out_ch1_duty))
    else $error("state changed without a transfer");
`endif

endmodule

// ----- rtl/msrk_regs.sv -----
module msrk_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output msrk_pkg::cfg_t      cfg
);

  msrk_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;
  logic [7:0]     rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        msrk_pkg::REG_ACCEL_RATE:    cfg_r.accel_rate    <= pwdata[7:0];
        msrk_pkg::REG_DECEL_RATE:    cfg_r.decel_rate    <= pwdata[7:0];
        msrk_pkg::REG_KICK_DURATION: cfg_r.kick_duration <= pwdata[7:0];
        msrk_pkg::REG_KICK_LEVEL:    cfg_r.kick_level    <= pwdata[7:0];
        msrk_pkg::REG_START_VOLTAGE: cfg_r.start_voltage <= pwdata[7:0];
        msrk_pkg::REG_HIGH_VOLTAGE:  cfg_r.high_voltage  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      msrk_pkg::REG_ACCEL_RATE:    rd_val = cfg_r.accel_rate;
      msrk_pkg::REG_DECEL_RATE:    rd_val = cfg_r.decel_rate;
      msrk_pkg::REG_KICK_DURATION: rd_val = cfg_r.kick_duration;
      msrk_pkg::REG_KICK_LEVEL:    rd_val = cfg_r.kick_level;
      msrk_pkg::REG_START_VOLTAGE: rd_val = cfg_r.start_voltage;
      msrk_pkg::REG_HIGH_VOLTAGE:  rd_val = cfg_r.high_voltage;
      default:                     rd_val = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_val};

endmodule

// ----- rtl/msrk_core.sv -----
module msrk_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  msrk_pkg::item_t     item,
  input  msrk_pkg::cfg_t      cfg,
  output logic [11:0]         duty_one,
  output logic [11:0]         duty_two,
  output logic [6:0]          speed,
  output logic [6:0]          target,
  output logic                dir
);

  localparam logic [9:0] PERIOD_LOAD = 10'(msrk_pkg::UPDATE_PERIOD);

  logic [6:0]  cur_speed_r, cur_speed_nxt;
  logic [6:0]  tgt_speed_r, tgt_speed_nxt;
  logic        cur_dir_r, cur_dir_nxt;
  logic [7:0]  rate_count_r, rate_count_nxt;
  logic [9:0]  period_count_r, period_count_nxt;
  logic [7:0]  kick_count_r, kick_count_nxt;
  logic [10:0] kick_amount_r, kick_amount_nxt;
  logic [11:0] duty_one_r, duty_one_nxt;
  logic [11:0] duty_two_r, duty_two_nxt;

  logic [9:0]  top_v;
  logic [9:0]  off_v;
  logic [9:0]  span;
  logic [2:0]  q_est;
  logic [7:0]  r_est;
  logic [3:0]  step;
  logic [10:0] speed_part;
  logic [12:0] duty_sum;
  logic [11:0] duty_sat;
  logic [7:0]  kick_dec;
  logic        refresh;
  logic        estop;

  // step = (top - off) / 127, one correction since span stays below 1024
  always_comb begin
    top_v = (cfg.high_voltage == 8'd0) ? 10'd1020 : {cfg.high_voltage, 2'b00};
    off_v = {cfg.start_voltage, 2'b00};
    span  = (off_v > top_v) ? 10'd0 : top_v - off_v;
    q_est = span[9:7];
    r_est = {1'b0, span[6:0]} + {5'd0, q_est};
    step  = (r_est >= 8'(msrk_pkg::SPEED_STEPS)) ? {1'b0, q_est} + 4'd1 : {1'b0, q_est};
  end

  always_comb begin
    cur_speed_nxt    = cur_speed_r;
    tgt_speed_nxt    = tgt_speed_r;
    cur_dir_nxt      = cur_dir_r;
    rate_count_nxt   = rate_count_r;
    period_count_nxt = period_count_r;
    kick_count_nxt   = kick_count_r;
    kick_amount_nxt  = kick_amount_r;
    refresh          = 1'b0;
    estop            = 1'b0;
    kick_dec         = (kick_count_r != 8'd0) ? kick_count_r - 8'd1 : 8'd0;

    if (item.req_type == msrk_pkg::REQ_TICK) begin
      kick_count_nxt = kick_dec;
      if (kick_dec == 8'd0 && kick_amount_r != 11'd0) begin
        kick_amount_nxt = 11'd0;
        refresh         = 1'b1;
      end
      if (period_count_r > 10'd1) begin
        period_count_nxt = period_count_r - 10'd1;
      end else begin
        period_count_nxt = PERIOD_LOAD;
        if (cur_speed_r != tgt_speed_r) begin
          if (rate_count_r != 8'd0) begin
            rate_count_nxt = rate_count_r - 8'd1;
          end else begin
            refresh = 1'b1;
            if (cur_speed_r < tgt_speed_r) begin
              rate_count_nxt = cfg.accel_rate;
              cur_speed_nxt  = cur_speed_r + 7'd1;
              if (kick_dec == 8'd0) begin
                kick_count_nxt = cfg.kick_duration;
                if (cfg.kick_duration != 8'd0) begin
                  kick_amount_nxt = (cur_speed_r != 7'd0) ? 11'd0 :
                                    11'(cfg.kick_level * msrk_pkg::KICK_SCALE);
                end
              end
            end else begin
              rate_count_nxt = cfg.decel_rate;
              cur_speed_nxt  = cur_speed_r - 7'd1;
            end
          end
        end
      end
    end else begin
      if (item.speed_value == msrk_pkg::SPEED_ESTOP) begin
        estop         = 1'b1;
        cur_speed_nxt = 7'd0;
        tgt_speed_nxt = 7'd0;
      end else if (cur_dir_r != item.direction) begin
        tgt_speed_nxt = 7'd0;
        if (cur_speed_r == 7'd0) begin
          cur_dir_nxt    = item.direction;
          tgt_speed_nxt  = item.speed_value;
          rate_count_nxt = (item.speed_value != 7'd0) ? cfg.accel_rate : cfg.decel_rate;
        end
      end else if (tgt_speed_r != item.speed_value) begin
        tgt_speed_nxt  = item.speed_value;
        rate_count_nxt = (cur_speed_r < item.speed_value) ? cfg.accel_rate : cfg.decel_rate;
      end
    end
  end

  // duty from the updated speed and kick, loaded on a refresh; estop zeroes both channels
  always_comb begin
    speed_part = 11'(cur_speed_nxt * step);
    duty_sum   = (cur_speed_nxt == 7'd0) ? {2'b00, kick_amount_nxt} :
                 {2'b00, speed_part} + {3'd0, off_v} + {2'b00, kick_amount_nxt};
    duty_sat   = (duty_sum > {1'b0, msrk_pkg::DUTY_MAX}) ? msrk_pkg::DUTY_MAX : duty_sum[11:0];

    duty_one_nxt = duty_one_r;
    duty_two_nxt = duty_two_r;
    if (estop) begin
      duty_one_nxt = 12'd0;
      duty_two_nxt = 12'd0;
    end else if (refresh) begin
      duty_one_nxt = cur_dir_nxt ? duty_sat : 12'd0;
      duty_two_nxt = cur_dir_nxt ? 12'd0 : duty_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_speed_r    <= 7'd0;
      tgt_speed_r    <= 7'd0;
      cur_dir_r      <= 1'b0;
      rate_count_r   <= 8'd0;
      period_count_r <= PERIOD_LOAD;
      kick_count_r   <= 8'd0;
      kick_amount_r  <= 11'd0;
      duty_one_r     <= 12'd0;
      duty_two_r     <= 12'd0;
    end else if (fire) begin
      cur_speed_r    <= cur_speed_nxt;
      tgt_speed_r    <= tgt_speed_nxt;
      cur_dir_r      <= cur_dir_nxt;
      rate_count_r   <= rate_count_nxt;
      period_count_r <= period_count_nxt;
      kick_count_r   <= kick_count_nxt;
      kick_amount_r  <= kick_amount_nxt;
      duty_one_r     <= duty_one_nxt;
      duty_two_r     <= duty_two_nxt;
    end
  end

  assign duty_one = duty_one_r;
  assign duty_two = duty_two_r;
  assign speed    = cur_speed_r;
  assign target   = tgt_speed_r;
  assign dir      = cur_dir_r;

endmodule
